// File: hdl/afod_pkg.sv
// Package for the flip orientation detector.
// Holds shared widths, register indexes, status codes and reset values.
// Used by the channel interfaces and every module of the block.
`default_nettype none

package afod_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int TIME_BITS_DEF   = 32;

   // Unit vector components are Q1.15; quotients need one more bit.
   localparam int UNIT_BITS  = 16;
   localparam int QUOT_BITS  = UNIT_BITS + 1;
   localparam int FRAC_SHIFT = UNIT_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int MAG_BITS       = 15;
   localparam int MAGSQ_BITS     = 2 * MAG_BITS;
   localparam int STATUS_BITS    = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DETECT_ENABLE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AXIS_FIRST      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AXIS_SECOND     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SAMPLE_INTERVAL = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STABLE_TIME     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_MAGNITUDE   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DOT_THRESHOLD   = 3'd6;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_SKIPPED   = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_WEAK      = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_AMBIGUOUS = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_MATCHES   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_PENDING   = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_WAITING   = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_FLIPPED   = 3'd6;

   localparam logic [15:0]        RST_SAMPLE_INTERVAL = 16'd100;
   localparam logic [15:0]        RST_STABLE_TIME     = 16'd500;
   localparam logic [MAG_BITS-1:0] RST_MIN_MAGNITUDE  = 15'd2048;
   localparam logic [MAG_BITS-1:0] RST_DOT_THRESHOLD  = 15'd23170;

   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

endpackage

`default_nettype wire

// File: hdl/afod_if.sv
// Channel interfaces of the flip orientation detector: sample request and
// status response, each with valid/ready handshake. Depends on afod_pkg.
`default_nettype none

interface afod_req_if
   import afod_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [TIME_BITS-1:0]          now_ms;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;
   logic                          cancel_pending;

   modport source (output valid, now_ms, accel_x, accel_y, accel_z, cancel_pending,
                   input ready);
   modport sink (input valid, now_ms, accel_x, accel_y, accel_z, cancel_pending,
                 output ready);
endinterface

interface afod_rsp_if
   import afod_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic                   shown_inverted;
   logic                   flipped;

   modport source (output valid, status, shown_inverted, flipped, input ready);
   modport sink (input valid, status, shown_inverted, flipped, output ready);
endinterface

`default_nettype wire

// File: hdl/afod_isqrt.sv
// Serial integer square root, one result bit per cycle.
// Depends on afod_pkg for the control struct.
`default_nettype none

module afod_isqrt
   import afod_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [2*SAMPLE_BITS-1:0]   radicand,
   output unit_ctl_type                    ctl,
   output logic [SAMPLE_BITS-1:0]          root
);
   localparam int RAD_W = 2 * SAMPLE_BITS;
   localparam int REM_W = SAMPLE_BITS + 3;
   localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [RAD_W-1:0]       rad_ff, rad_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] root_ff, root_in;
   logic [REM_W-1:0]       rem_shift;
   logic [REM_W-1:0]       trial;

   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = REM_W'({root_ff, 2'b01});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[SAMPLE_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[SAMPLE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SAMPLE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign ctl.start = start;
   assign ctl.done  = done_ff;
   assign root      = root_ff;

endmodule

`default_nettype wire

// File: hdl/afod_divider.sv
// Serial restoring divider for unit vector components: computes
// (ua * 65536 + mag) / (2 * mag), one quotient bit per cycle. Uses afod_pkg.
`default_nettype none

module afod_divider
   import afod_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [SAMPLE_BITS-1:0] ua,
   input  wire logic [SAMPLE_BITS-1:0] mag,
   output unit_ctl_type                ctl,
   output logic [QUOT_BITS-1:0]        quotient
);
   localparam int NUM_W = SAMPLE_BITS + FRAC_SHIFT + 1;
   localparam int REM_W = SAMPLE_BITS + 1;
   localparam int CNT_W = $clog2(QUOT_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [REM_W-1:0]     div_ff, div_in;
   logic [QUOT_BITS-1:0] low_ff, low_in;
   logic [NUM_W-1:0]     numer;
   logic [REM_W:0]       rem_shift;

   // The upper numerator bits are already below the divisor since ua <= mag,
   // so only the quotient-bit positions need an iteration.
   assign numer     = NUM_W'({ua, {FRAC_SHIFT{1'b0}}}) + NUM_W'(mag);
   assign rem_shift = {rem_ff, low_ff[QUOT_BITS-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      low_in  = low_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = REM_W'(numer[NUM_W-1:QUOT_BITS]);
         low_in  = numer[QUOT_BITS-1:0];
         div_in  = {mag, 1'b0};
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, div_ff}) begin
            rem_in = REM_W'(rem_shift - {1'b0, div_ff});
            low_in = {low_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            rem_in = REM_W'(rem_shift);
            low_in = {low_ff[QUOT_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      low_ff <= low_in;
   end

   assign ctl.start = start;
   assign ctl.done  = done_ff;
   assign quotient  = low_ff;

endmodule

`default_nettype wire

// File: hdl/accel_flip_orientation_detector.sv
// A skipped or cancelled sample goes from idle straight to the done state; a full sample
// passes the square, check, root, two serial 17-step division, dot, classify (once a
// baseline is held) and decide states, and weak or ambiguous ones end early. The done
// state registers each result once the response register is free. Throughput: one
// sample at a time; the next is accepted the cycle after the result is registered.
// Reset (synchronous, active high) restores register defaults and clears control and detector state.
`default_nettype none

module accel_flip_orientation_detector
   import afod_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   afod_req_if.sink                       req_bus,
   afod_rsp_if.source                     rsp_bus,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);
   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int CMP_W = (SQ_W > MAGSQ_BITS) ? SQ_W : MAGSQ_BITS;
   localparam int PROD_W = 2 * UNIT_BITS;
   localparam int DOT_W  = PROD_W + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_SQUARE, S_CHECK, S_ROOT, S_DIV1, S_DIV2, S_DOT, S_CLASS, S_DECIDE, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration.
   logic                   enable_ff, enable_in;
   logic [1:0]             axis1_ff, axis1_in, axis2_ff, axis2_in;
   logic [15:0]            interval_ff, interval_in, stable_ff, stable_in;
   logic [MAG_BITS-1:0]    minmag_ff, minmag_in, thresh_ff, thresh_in;

   // Persistent detector state.
   logic                   taken_ff, taken_in;
   logic [TIME_BITS-1:0]   last_ff, last_in;
   logic                   base_rdy_ff, base_rdy_in;
   logic signed [UNIT_BITS-1:0] base1_ff, base1_in, base2_ff, base2_in;
   logic                   inv_now_ff, inv_now_in;
   logic                   pend_ff, pend_in;
   logic                   pend_or_ff, pend_or_in;
   logic [TIME_BITS-1:0]   pend_since_ff, pend_since_in;

   // Per-transaction working registers.
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [SAMPLE_BITS-1:0] ua1_ff, ua1_in, ua2_ff, ua2_in;
   logic                   neg1_ff, neg1_in, neg2_ff, neg2_in;
   logic [SQ_W-1:0]        sq1_ff, sq1_in, sq2_ff, sq2_in;
   logic [MAGSQ_BITS-1:0]  minsq_ff, minsq_in;
   logic [SAMPLE_BITS-1:0] mag_ff, mag_in;
   logic signed [UNIT_BITS-1:0] n1_ff, n1_in, n2_ff, n2_in;
   logic signed [PROD_W-1:0] prod1_ff, prod1_in, prod2_ff, prod2_in;
   logic                   det_ff, det_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic                   rsp_inv_ff, rsp_inv_in;
   logic                   rsp_flip_ff, rsp_flip_in;

   // Datapath helpers.
   logic                   accept;
   logic signed [SAMPLE_BITS-1:0] sel1, sel2;
   logic [SQ_W-1:0]        sq_sum;
   logic                   weak_vec;
   logic                   root_start, div_start;
   logic [SAMPLE_BITS-1:0] root_val, div_ua, div_mag;
   logic [QUOT_BITS-1:0]   quot;
   logic signed [UNIT_BITS-1:0] unit_val;
   logic                   unit_neg;
   logic signed [DOT_W-1:0] dot, thr;
   unit_ctl_type           root_ctl, div_ctl;

   function automatic logic signed [SAMPLE_BITS-1:0] pick_axis(
      input logic [1:0] sel,
      input logic signed [SAMPLE_BITS-1:0] x,
      input logic signed [SAMPLE_BITS-1:0] y,
      input logic signed [SAMPLE_BITS-1:0] z
   );
      logic signed [SAMPLE_BITS-1:0] r;
      case (sel)
         AXIS_X:  r = x;
         AXIS_Z:  r = z;
         default: r = y;
      endcase
      return r;
   endfunction

   assign accept = req_bus.valid && req_bus.ready;
   assign sel1 = pick_axis(axis1_ff, req_bus.accel_x, req_bus.accel_y, req_bus.accel_z);
   assign sel2 = pick_axis(axis2_ff, req_bus.accel_x, req_bus.accel_y, req_bus.accel_z);
   assign sq_sum = sq1_ff + sq2_ff;
   assign weak_vec = (sq_sum == '0) || (CMP_W'(sq_sum) < CMP_W'(minsq_ff));

   assign root_start = (state_ff == S_CHECK) && !weak_vec;
   assign div_start  = ((state_ff == S_ROOT) && root_ctl.done) ||
                       ((state_ff == S_DIV1) && div_ctl.done);
   assign div_ua     = (state_ff == S_ROOT) ? ua1_ff : ua2_ff;
   // The first division starts in the same cycle the root is captured.
   assign div_mag    = (state_ff == S_ROOT) ? root_val : mag_ff;
   assign unit_neg   = (state_ff == S_DIV1) ? neg1_ff : neg2_ff;

   // Round-half-away quotient saturated to the Q1.15 range.
   always_comb begin
      if (unit_neg) begin
         if (quot > QUOT_BITS'(32768)) begin
            unit_val = UNIT_BITS'(-32768);
         end else begin
            unit_val = UNIT_BITS'(QUOT_BITS'(0) - quot);
         end
      end else begin
         if (quot > QUOT_BITS'(32767)) begin
            unit_val = UNIT_BITS'(32767);
         end else begin
            unit_val = UNIT_BITS'(quot);
         end
      end
   end

   assign dot = DOT_W'(prod1_ff) + DOT_W'(prod2_ff);
   assign thr = DOT_W'({thresh_ff, {(UNIT_BITS-1){1'b0}}});

   afod_isqrt #(.SAMPLE_BITS(SAMPLE_BITS)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sq_sum),
      .ctl      (root_ctl),
      .root     (root_val)
   );

   afod_divider #(.SAMPLE_BITS(SAMPLE_BITS)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .ua       (div_ua),
      .mag      (div_mag),
      .ctl      (div_ctl),
      .quotient (quot)
   );

   always_comb begin
      state_in      = state_ff;
      enable_in     = enable_ff;
      axis1_in      = axis1_ff;
      axis2_in      = axis2_ff;
      interval_in   = interval_ff;
      stable_in     = stable_ff;
      minmag_in     = minmag_ff;
      thresh_in     = thresh_ff;
      taken_in      = taken_ff;
      last_in       = last_ff;
      base_rdy_in   = base_rdy_ff;
      base1_in      = base1_ff;
      base2_in      = base2_ff;
      inv_now_in    = inv_now_ff;
      pend_in       = pend_ff;
      pend_or_in    = pend_or_ff;
      pend_since_in = pend_since_ff;
      now_in        = now_ff;
      ua1_in        = ua1_ff;
      ua2_in        = ua2_ff;
      neg1_in       = neg1_ff;
      neg2_in       = neg2_ff;
      sq1_in        = sq1_ff;
      sq2_in        = sq2_ff;
      minsq_in      = minsq_ff;
      mag_in        = mag_ff;
      n1_in         = n1_ff;
      n2_in         = n2_ff;
      prod1_in      = prod1_ff;
      prod2_in      = prod2_ff;
      det_in        = det_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_inv_in    = rsp_inv_ff;
      rsp_flip_in   = rsp_flip_ff;

      if (csr_write_en) begin
         case (csr_index)
            REG_DETECT_ENABLE:   enable_in   = csr_wdata[0];
            REG_AXIS_FIRST:      axis1_in    = csr_wdata[1:0];
            REG_AXIS_SECOND:     axis2_in    = csr_wdata[1:0];
            REG_SAMPLE_INTERVAL: interval_in = csr_wdata;
            REG_STABLE_TIME:     stable_in   = csr_wdata;
            REG_MIN_MAGNITUDE:   minmag_in   = csr_wdata[MAG_BITS-1:0];
            REG_DOT_THRESHOLD:   thresh_in   = csr_wdata[MAG_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in    = req_bus.now_ms;
               status_in = ST_SKIPPED;
               state_in  = S_DONE;
               if (req_bus.cancel_pending) begin
                  pend_in = 1'b0;
               end else if (enable_ff && !(taken_ff &&
                            (req_bus.now_ms - last_ff) < TIME_BITS'(interval_ff))) begin
                  taken_in = 1'b1;
                  last_in  = req_bus.now_ms;
                  neg1_in  = sel1[SAMPLE_BITS-1];
                  neg2_in  = sel2[SAMPLE_BITS-1];
                  ua1_in   = sel1[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sel1) : sel1;
                  ua2_in   = sel2[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sel2) : sel2;
                  state_in = S_SQUARE;
               end
            end
         end
         S_SQUARE: begin
            sq1_in   = SQ_W'(ua1_ff) * SQ_W'(ua1_ff);
            sq2_in   = SQ_W'(ua2_ff) * SQ_W'(ua2_ff);
            minsq_in = MAGSQ_BITS'(minmag_ff) * MAGSQ_BITS'(minmag_ff);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (weak_vec) begin
               status_in = ST_WEAK;
               state_in  = S_DONE;
            end else begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (root_ctl.done) begin
               mag_in   = root_val;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            if (div_ctl.done) begin
               n1_in    = unit_val;
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_ctl.done) begin
               n2_in    = unit_val;
               state_in = S_DOT;
            end
         end
         S_DOT: begin
            if (!base_rdy_ff) begin
               base1_in    = n1_ff;
               base2_in    = n2_ff;
               base_rdy_in = 1'b1;
               det_in      = 1'b0;
               state_in    = S_DECIDE;
            end else begin
               prod1_in = base1_ff * n1_ff;
               prod2_in = base2_ff * n2_ff;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            if (dot > thr) begin
               det_in   = 1'b0;
               state_in = S_DECIDE;
            end else if (dot < -thr) begin
               det_in   = 1'b1;
               state_in = S_DECIDE;
            end else begin
               status_in = ST_AMBIGUOUS;
               state_in  = S_DONE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            if (det_ff == inv_now_ff) begin
               pend_in   = 1'b0;
               status_in = ST_MATCHES;
            end else if (!pend_ff || pend_or_ff != det_ff) begin
               pend_or_in    = det_ff;
               pend_since_in = now_ff;
               pend_in       = 1'b1;
               status_in     = ST_PENDING;
            end else if ((now_ff - pend_since_ff) < TIME_BITS'(stable_ff)) begin
               status_in = ST_WAITING;
            end else begin
               pend_in    = 1'b0;
               inv_now_in = det_ff;
               status_in  = ST_FLIPPED;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_inv_in    = inv_now_ff;
               rsp_flip_in   = (status_ff == ST_FLIPPED);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         enable_ff     <= 1'b0;
         axis1_ff      <= AXIS_X;
         axis2_ff      <= AXIS_Y;
         interval_ff   <= RST_SAMPLE_INTERVAL;
         stable_ff     <= RST_STABLE_TIME;
         minmag_ff     <= RST_MIN_MAGNITUDE;
         thresh_ff     <= RST_DOT_THRESHOLD;
         taken_ff      <= 1'b0;
         last_ff       <= '0;
         base_rdy_ff   <= 1'b0;
         base1_ff      <= '0;
         base2_ff      <= '0;
         inv_now_ff    <= 1'b0;
         pend_ff       <= 1'b0;
         pend_or_ff    <= 1'b0;
         pend_since_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enable_ff     <= enable_in;
         axis1_ff      <= axis1_in;
         axis2_ff      <= axis2_in;
         interval_ff   <= interval_in;
         stable_ff     <= stable_in;
         minmag_ff     <= minmag_in;
         thresh_ff     <= thresh_in;
         taken_ff      <= taken_in;
         last_ff       <= last_in;
         base_rdy_ff   <= base_rdy_in;
         base1_ff      <= base1_in;
         base2_ff      <= base2_in;
         inv_now_ff    <= inv_now_in;
         pend_ff       <= pend_in;
         pend_or_ff    <= pend_or_in;
         pend_since_ff <= pend_since_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      now_ff        <= now_in;
      ua1_ff        <= ua1_in;
      ua2_ff        <= ua2_in;
      neg1_ff       <= neg1_in;
      neg2_ff       <= neg2_in;
      sq1_ff        <= sq1_in;
      sq2_ff        <= sq2_in;
      minsq_ff      <= minsq_in;
      mag_ff        <= mag_in;
      n1_ff         <= n1_in;
      n2_ff         <= n2_in;
      prod1_ff      <= prod1_in;
      prod2_ff      <= prod2_in;
      det_ff        <= det_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_inv_ff    <= rsp_inv_in;
      rsp_flip_ff   <= rsp_flip_in;
   end

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.shown_inverted = rsp_inv_ff;
   assign rsp_bus.flipped        = rsp_flip_ff;

   // A transaction is processed alone: no new sample until the current one is done.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_bus.ready)
      else $error("sample accepted while another is in flight");

   // The flip flag agrees with the status code of every response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.flipped == (rsp_bus.status == ST_FLIPPED)))
      else $error("flip flag disagrees with status");

   // A committed flip always retires the pending change.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && status_in == ST_FLIPPED) |=> !pend_ff)
      else $error("pending change survived a flip");

   // The divider is only ever started while the root or the first division retires.
   assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> (root_ctl.done || div_ctl.done))
      else $error("divider started without a finished operand");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the flip orientation detector.
// Depends on afod_pkg, the afod_req_if/afod_rsp_if interfaces and the block itself.
`default_nettype none

module testbench;
   import afod_pkg::*;

   localparam int LIMIT_CYCLES = 1500000;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   shown_inverted;
      logic                   flipped;
   } verdict_type;

   class flip_scoreboard;
      // Configuration copy
      bit        en;
      bit [1:0]  ax1, ax2;
      bit [15:0] interval, stable;
      bit [14:0] min_mag, thr;
      // Detector state copy
      bit          taken, base_ok, inv_now, pend_v, pend_o;
      bit [31:0]   last_t, pend_t;
      longint      base1, base2;
      verdict_type expected_q[$];
      int          errors, checked;
      int          status_seen[8];

      function void clear();
         en = 0; ax1 = AXIS_X; ax2 = AXIS_Y; interval = RST_SAMPLE_INTERVAL;
         stable = RST_STABLE_TIME; min_mag = RST_MIN_MAGNITUDE; thr = RST_DOT_THRESHOLD;
         taken = 0; base_ok = 0; inv_now = 0; pend_v = 0; pend_o = 0;
         last_t = 0; pend_t = 0; base1 = 0; base2 = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] v);
         case (idx)
            REG_DETECT_ENABLE:   en = v[0];
            REG_AXIS_FIRST:      ax1 = v[1:0];
            REG_AXIS_SECOND:     ax2 = v[1:0];
            REG_SAMPLE_INTERVAL: interval = v;
            REG_STABLE_TIME:     stable = v;
            REG_MIN_MAGNITUDE:   min_mag = v[14:0];
            REG_DOT_THRESHOLD:   thr = v[14:0];
            default: ;
         endcase
      endfunction

      function longint axis_of(bit [1:0] sel, longint x, longint y, longint z);
         if (sel == AXIS_X) return x;
         if (sel == AXIS_Z) return z;
         return y;
      endfunction

      function longint root_floor(longint s);
         longint r;
         r = longint'($sqrt(real'(s)));
         while (r * r > s) r--;
         while ((r + 1) * (r + 1) <= s) r++;
         return r;
      endfunction

      function longint unit_part(longint a, longint mag);
         longint ua, q;
         ua = (a < 0) ? -a : a;
         q = (ua * 65536 + mag) / (2 * mag);
         if (a < 0) return (q > 32768) ? -32768 : -q;
         return (q > 32767) ? 32767 : q;
      endfunction

      function logic [STATUS_BITS-1:0] orient(bit [31:0] now, logic signed [15:0] x,
                                               logic signed [15:0] y, logic signed [15:0] z,
                                               bit cancel);
         longint a1, a2, s, mag, n1, n2, dot, t;
         bit det;
         if (cancel) begin
            pend_v = 0;
            return ST_SKIPPED;
         end
         if (!en) return ST_SKIPPED;
         if (taken && (now - last_t) < {16'd0, interval}) return ST_SKIPPED;
         taken = 1;
         last_t = now;
         a1 = axis_of(ax1, x, y, z);
         a2 = axis_of(ax2, x, y, z);
         s = a1 * a1 + a2 * a2;
         if (s == 0 || s < longint'(min_mag) * longint'(min_mag)) return ST_WEAK;
         mag = root_floor(s);
         n1 = unit_part(a1, mag);
         n2 = unit_part(a2, mag);
         if (!base_ok) begin
            base1 = n1; base2 = n2; base_ok = 1; det = 0;
         end else begin
            dot = base1 * n1 + base2 * n2;
            t = longint'(thr) << 15;
            if (dot > t) det = 0;
            else if (dot < -t) det = 1;
            else return ST_AMBIGUOUS;
         end
         if (det == inv_now) begin
            pend_v = 0;
            return ST_MATCHES;
         end
         if (!pend_v || pend_o != det) begin
            pend_o = det; pend_t = now; pend_v = 1;
            return ST_PENDING;
         end
         if ((now - pend_t) < {16'd0, stable}) return ST_WAITING;
         pend_v = 0;
         inv_now = det;
         return ST_FLIPPED;
      endfunction

      function void note_sample(bit [31:0] now, logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z, bit cancel);
         verdict_type v;
         v.status = orient(now, x, y, z, cancel);
         v.shown_inverted = inv_now;
         v.flipped = (v.status == ST_FLIPPED);
         expected_q.push_back(v);
      endfunction

      function void check_result(verdict_type got);
         verdict_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected result %p", got);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         status_seen[got.status]++;
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: result %0d expected status=%0d inv=%0b flip=%0b, got %0d %0b %0b",
                        checked, want.status, want.shown_inverted, want.flipped,
                        got.status, got.shown_inverted, got.flipped);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_write_en = 0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic quiet = 0;
   longint cycles = 0;

   afod_req_if req_bus ();
   afod_rsp_if rsp_bus ();

   accel_flip_orientation_detector u_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   flip_scoreboard board;
   bit [31:0] clock_ms;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      req_bus.valid = 0; req_bus.now_ms = '0; req_bus.accel_x = '0;
      req_bus.accel_y = '0; req_bus.accel_z = '0; req_bus.cancel_pending = 0;
      rsp_bus.ready = 0;
   end

   // Result side: random stall bursts, checks on accepted transactions.
   initial begin
      int stall;
      verdict_type got;
      board = new();
      board.clear();
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.status = rsp_bus.status;
            got.shown_inverted = rsp_bus.shown_inverted;
            got.flipped = rsp_bus.flipped;
            board.check_result(got);
         end
         if (stall > 0) stall--;
         else if (!quiet && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 12);
         rsp_bus.ready <= (stall == 0);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT_CYCLES) begin
            $display("accel_flip_orientation_detector verification failed");
            $finish;
         end
      end
   end

   // The block is never ready in the cycle after an acceptance, so the wait for a clock
   // edge at the start of the next send before raising valid again costs no throughput.
   task automatic send_sample(bit [31:0] now, logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z, bit cancel);
      @(posedge clock);
      if (!quiet && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 12)) @(posedge clock);
      req_bus.valid <= 1;
      req_bus.now_ms <= now;
      req_bus.accel_x <= x;
      req_bus.accel_y <= y;
      req_bus.accel_z <= z;
      req_bus.cancel_pending <= cancel;
      do @(posedge clock); while (!req_bus.ready);
      board.note_sample(now, x, y, z, cancel);
      req_bus.valid <= 0;
   endtask

   task automatic drain();
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] v);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.write_reg(idx, v);
   endtask

   task automatic setup(bit en, bit [1:0] a1, bit [1:0] a2, bit [15:0] iv, bit [15:0] st,
                        bit [14:0] mm, bit [14:0] th);
      drain();
      write_reg(REG_DETECT_ENABLE, {15'd0, en});
      write_reg(REG_AXIS_FIRST, {14'd0, a1});
      write_reg(REG_AXIS_SECOND, {14'd0, a2});
      write_reg(REG_SAMPLE_INTERVAL, iv);
      write_reg(REG_STABLE_TIME, st);
      write_reg(REG_MIN_MAGNITUDE, {1'b0, mm});
      write_reg(REG_DOT_THRESHOLD, {1'b0, th});
      csr_write_en <= 0;
   endtask

   // Mostly gravity along the second chosen axis, upright or upside down, with jitter.
   task automatic random_sample();
      logic signed [15:0] v[3];
      int kind, sign;
      kind = $urandom_range(0, 99);
      clock_ms += $urandom_range(0, 99) < 80 ? $urandom_range(0, 300) : $urandom();
      if (kind < 70) begin
         sign = $urandom_range(0, 1) ? 1 : -1;
         foreach (v[i]) v[i] = 16'($urandom_range(0, 1200) - 600);
         v[board.ax2] = 16'(sign * (3000 + $urandom_range(0, 20000)));
      end else if (kind < 85) begin
         foreach (v[i]) v[i] = 16'($urandom());
      end else begin
         foreach (v[i]) v[i] = 16'($urandom_range(0, 4000) - 2000);
      end
      send_sample(clock_ms, v[0], v[1], v[2], $urandom_range(0, 99) < 4);
   endtask

   initial begin
      int phase;
      clock_ms = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: disabled, then extremes with baseline, flips, cancel and wrap.
      send_sample(32'd0, 16'sd100, 16'sd4096, 16'sd0, 0);
      setup(1, AXIS_X, AXIS_Y, 16'd0, 16'd0, 15'd0, 15'd23170);
      send_sample(32'd0, 16'sd0, 16'sd0, 16'sd0, 0);
      send_sample(32'd1, -16'sd32768, -16'sd32768, 16'sd0, 0);
      send_sample(32'd2, 16'sd32767, 16'sd32767, 16'sd0, 0);
      send_sample(32'd3, 16'sd32767, -16'sd32768, 16'sd0, 0);
      send_sample(32'd4, -16'sd1, 16'sd0, 16'sd0, 0);
      send_sample(32'd5, 16'sd1, 16'sd0, 16'sd0, 1);
      send_sample(32'd6, -16'sd32768, -16'sd32768, -16'sd32768, 0);
      send_sample(32'd7, 16'sd32767, 16'sd32767, 16'sd32767, 0);
      setup(1, 2'd3, AXIS_Z, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
      send_sample(32'hFFFF_FFF0, 16'sd0, 16'sd32767, 16'sd0, 0);
      send_sample(32'h0000_FFEF, 16'sd0, 16'sd32767, 16'sd0, 0);
      send_sample(32'h0000_FFF0, 16'sd0, 16'sd32767, 16'sd32767, 0);
      setup(1, AXIS_Y, AXIS_Z, 16'd100, 16'd500, 15'd2048, 15'd0);
      send_sample(32'h0010_0000, 16'sd0, 16'sd0, -16'sd4096, 0);
      send_sample(32'h0010_0064, 16'sd0, 16'sd0, 16'sd4096, 0);
      send_sample(32'h0010_0300, 16'sd0, 16'sd0, 16'sd4096, 1);
      send_sample(32'h0010_0400, 16'sd0, 16'sd4096, 16'sd0, 0);
      send_sample(32'h0010_0500, 16'sd0, 16'sd0, 16'sd4096, 0);
      send_sample(32'h0010_0900, 16'sd0, 16'sd0, 16'sd4096, 0);
      send_sample(32'h0010_1000, 16'sd0, 16'sd0, -16'sd4096, 0);

      // Random phases with different settings; sender waits on a drain each time.
      for (phase = 0; phase < 9; phase++) begin
         if (phase == 8) quiet = 1;
         setup(phase != 3, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 2)),
               $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(0, 150)),
               $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 600)),
               $urandom_range(0, 4) == 0 ? 15'h7FFF : 15'($urandom_range(0, 4000)),
               $urandom_range(0, 4) == 0 ? 15'd0 : 15'($urandom_range(10000, 32767)));
         repeat (150) random_sample();
      end
      drain();

      $display("Checked %0d results: skipped %0d weak %0d ambiguous %0d matches %0d",
               board.checked, board.status_seen[0], board.status_seen[1],
               board.status_seen[2], board.status_seen[3]);
      $display("pending %0d waiting %0d flipped %0d", board.status_seen[4],
               board.status_seen[5], board.status_seen[6]);
      if (board.errors == 0 && board.expected_q.size() == 0)
         $display("accel_flip_orientation_detector verification clean");
      else
         $display("accel_flip_orientation_detector verification failed");
      $finish;
   end
endmodule

`default_nettype wire

// File: filelist.f
hdl/afod_pkg.sv
hdl/afod_if.sv
hdl/afod_isqrt.sv
hdl/afod_divider.sv
hdl/accel_flip_orientation_detector.sv
tb/sv/testbench.sv
